### rtl/lda_pkg.sv
// ----------------------------------------------------------------------------
// lda_pkg
// shared widths and constants for the light distance attenuation pipeline
// ----------------------------------------------------------------------------
package lda_pkg;
  localparam int OffsetBits   = 11;
  localparam int RadiusBits   = 10;
  localparam int FractionBits = 16;
  localparam int FactorBits   = FractionBits + 1;
  localparam int AbsBits      = OffsetBits;               // |-1024| fits
  localparam int D2Bits       = 2 * AbsBits + 1;          // 23
  localparam int RadicandBits = D2Bits + 16;              // 39, d2 << 16
  localparam int RootBits     = (RadicandBits + 1) / 2;   // 20
  localparam int SqrtSteps    = RootBits;                 // one root bit per stage
  localparam int R2Bits       = 2 * RadiusBits;
  localparam int DenBits      = D2Bits + 3;               // r2 + 4*d2
  localparam int DropBits     = RootBits + FractionBits - 8; // 28
  localparam int DivSteps     = FactorBits;               // quotient bits needed
  localparam int AddrBits     = 3;

  localparam logic [AddrBits-1:0] AddrRadius = 3'h0;
  localparam logic [AddrBits-1:0] AddrMode   = 3'h4;

  typedef enum logic {
    ModeLinear  = 1'b0,
    ModeInvSq   = 1'b1
  } falloff_e;

  typedef struct packed {
    logic [RadiusBits-1:0] radius;
    falloff_e              mode;
  } cfg_t;
endpackage

### rtl/lda_regs.sv
// ----------------------------------------------------------------------------
// lda_regs
// apb register file holding radius and falloff mode
// ----------------------------------------------------------------------------
module lda_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lda_pkg::AddrBits-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output lda_pkg::cfg_t                  cfg_o
);
  logic [lda_pkg::RadiusBits-1:0] radius_q;
  logic                           mode_q;
  logic                           wr;

  assign pready = 1'b1;
  assign wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= '0;
      mode_q   <= 1'b0;
    end else if (wr) begin
      if (paddr == lda_pkg::AddrRadius) radius_q <= pwdata[lda_pkg::RadiusBits-1:0];
      if (paddr == lda_pkg::AddrMode)   mode_q   <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == lda_pkg::AddrRadius) prdata[lda_pkg::RadiusBits-1:0] = radius_q;
    else if (paddr == lda_pkg::AddrMode) prdata[0] = mode_q;
  end

  assign cfg_o.radius = radius_q;
  assign cfg_o.mode   = lda_pkg::falloff_e'(mode_q);
endmodule

### rtl/lda_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// lda_sqrt_pipe
// squares the offsets, then a restoring square root, one root bit per stage
// ----------------------------------------------------------------------------
module lda_sqrt_pipe (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic signed [lda_pkg::OffsetBits-1:0] offset_x_i,
  input  logic signed [lda_pkg::OffsetBits-1:0] offset_y_i,
  output logic                                valid_o,
  output logic [lda_pkg::D2Bits-1:0]          d2_o,
  output logic [lda_pkg::RootBits-1:0]        root_o
);
  localparam int N = lda_pkg::SqrtSteps;
  localparam int RB = lda_pkg::RootBits;
  localparam int RemBits = RB + 2;

  logic [lda_pkg::AbsBits-1:0] ax, ay;
  logic [lda_pkg::D2Bits-1:0]  sq_d;
  logic [lda_pkg::D2Bits-1:0]  sq_q;
  logic                        sq_vld_q;

  logic [N:0]                       vld_q;
  logic [lda_pkg::D2Bits-1:0]       d2_q   [N+1];
  logic [2*RB-1:0]                  rad_q  [N+1];
  logic [RemBits-1:0]               rem_q  [N+1];
  logic [RB-1:0]                    root_q [N+1];

  assign ax = offset_x_i[lda_pkg::OffsetBits-1] ? lda_pkg::AbsBits'(-offset_x_i)
                                                : lda_pkg::AbsBits'(offset_x_i);
  assign ay = offset_y_i[lda_pkg::OffsetBits-1] ? lda_pkg::AbsBits'(-offset_y_i)
                                                : lda_pkg::AbsBits'(offset_y_i);
  assign sq_d = lda_pkg::D2Bits'(ax * ax) + lda_pkg::D2Bits'(ay * ay);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q <= 1'b0;
      vld_q    <= '0;
    end else if (en_i) begin
      sq_vld_q <= valid_i;
      vld_q    <= {vld_q[N-1:0], sq_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q     <= sq_d;
      d2_q[0]  <= sq_q;
      rad_q[0] <= (2*RB)'({sq_q, 16'h0000});
      rem_q[0] <= '0;
      root_q[0] <= '0;
    end
  end

  // each stage brings down two radicand bits and decides one root bit
  for (genvar s = 0; s < N; s++) begin : g_step
    logic [RemBits-1:0] trial_rem;
    logic [RemBits-1:0] trial_sub;
    assign trial_rem = {rem_q[s][RemBits-3:0], rad_q[s][2*RB-1 -: 2]};
    assign trial_sub = {root_q[s], 2'b01};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d2_q[s+1]  <= d2_q[s];
        rad_q[s+1] <= {rad_q[s][2*RB-3:0], 2'b00};
        if (trial_rem >= trial_sub) begin
          rem_q[s+1]  <= trial_rem - trial_sub;
          root_q[s+1] <= {root_q[s][RB-2:0], 1'b1};
        end else begin
          rem_q[s+1]  <= trial_rem;
          root_q[s+1] <= {root_q[s][RB-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = vld_q[N];
  assign d2_o    = d2_q[N];
  assign root_o  = root_q[N];
endmodule

### rtl/lda_div_pipe.sv
// ----------------------------------------------------------------------------
// lda_div_pipe
// forms numerator and denominator per mode, then restoring division one
// quotient bit per stage, and clamps
// ----------------------------------------------------------------------------
module lda_div_pipe (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  lda_pkg::cfg_t                 cfg_i,
  input  logic                          valid_i,
  input  logic [lda_pkg::D2Bits-1:0]    d2_i,
  input  logic [lda_pkg::RootBits-1:0]  root_i,
  output logic                          valid_o,
  output logic [lda_pkg::FactorBits-1:0] factor_o
);
  localparam int N  = lda_pkg::DivSteps;
  localparam int NB = lda_pkg::DropBits;          // numerator width
  localparam int DB = lda_pkg::DenBits;
  localparam int FB = lda_pkg::FactorBits;

  // linear: drop = (root << 8) / r ; quotient bits above FB only saturate.
  // inv-sq: r2 * 2^16 / (r2 + 4 d2), quotient <= 2^16.
  logic [lda_pkg::R2Bits-1:0] r2_q;
  logic [lda_pkg::D2Bits-1:0] d2_q;
  logic [lda_pkg::RootBits-1:0] rt_q;
  logic                       pre_vld_q;

  logic [N:0]          vld_q;
  logic [NB-1:0]       num_q  [N+1];
  logic [DB-1:0]       den_q  [N+1];
  logic [DB:0]         rem_q  [N+1];
  logic [FB-1:0]       quo_q  [N+1];
  logic                big_q  [N+1];
  logic                zero_q [N+1];
  logic                lin_q  [N+1];

  logic [NB-1:0] num_d;
  logic [DB-1:0] den_d;
  logic          big_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_vld_q <= 1'b0;
      vld_q     <= '0;
    end else if (en_i) begin
      pre_vld_q <= valid_i;
      vld_q     <= {vld_q[N-1:0], pre_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r2_q <= lda_pkg::R2Bits'(cfg_i.radius * cfg_i.radius);
      d2_q <= d2_i;
      rt_q <= root_i;
    end
  end

  // the linear quotient reaches 2^16 or more exactly when root<<8 >= r<<16
  // inverse-square dividend tail below the starting remainder: r2[0] then 16 zeros
  always_comb begin
    if (cfg_i.mode == lda_pkg::ModeLinear) begin
      num_d = NB'({rt_q, 8'h00});
      den_d = DB'(cfg_i.radius);
      big_d = ({rt_q, 8'h00} >= ({10'd0, cfg_i.radius} << 16));
    end else begin
      num_d = NB'({r2_q[0], 16'h0000});
      den_d = DB'(r2_q) + DB'({d2_q, 2'b00});
      big_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lin_q[0]  <= (cfg_i.mode == lda_pkg::ModeLinear);
      zero_q[0] <= (cfg_i.radius == '0);
      big_q[0]  <= big_d;
      den_q[0]  <= den_d;
      quo_q[0]  <= '0;
      num_q[0]  <= num_d << (NB - FB);
      if (cfg_i.mode == lda_pkg::ModeLinear) begin
        // quotient < 2^17 since not big: top dividend bits above bit FB
        // fold into the starting remainder
        rem_q[0] <= (DB+1)'(num_d >> FB);
      end else begin
        // r2*2^16 >> 17 = r2 >> 1, remainder start
        rem_q[0] <= (DB+1)'(r2_q >> 1);
      end
    end
  end

  for (genvar s = 0; s < N; s++) begin : g_step
    logic [DB:0] trial;
    assign trial = {rem_q[s][DB-1:0], num_q[s][NB-1]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s+1]  <= {num_q[s][NB-2:0], 1'b0};
        den_q[s+1]  <= den_q[s];
        big_q[s+1]  <= big_q[s];
        zero_q[s+1] <= zero_q[s];
        lin_q[s+1]  <= lin_q[s];
        if (trial >= {1'b0, den_q[s]}) begin
          rem_q[s+1] <= trial - {1'b0, den_q[s]};
          quo_q[s+1] <= {quo_q[s][FB-2:0], 1'b1};
        end else begin
          rem_q[s+1] <= trial;
          quo_q[s+1] <= {quo_q[s][FB-2:0], 1'b0};
        end
      end
    end
  end

  localparam logic [FB-1:0] Unity = FB'(1) << lda_pkg::FractionBits;

  always_comb begin
    if (zero_q[N]) factor_o = '0;
    else if (!lin_q[N]) factor_o = quo_q[N];
    else if (big_q[N] || quo_q[N] >= Unity) factor_o = '0;
    else factor_o = Unity - quo_q[N];
  end

  assign valid_o = vld_q[N];
endmodule

### rtl/light_distance_attenuation.sv
// ----------------------------------------------------------------------------
// light_distance_attenuation
// distance attenuation factor, linear or inverse square, fully pipelined
// ----------------------------------------------------------------------------
// channel   dir  handshake              payload
// in        in   in_valid_i/in_ready_o  offset_x_i, offset_y_i
// out       out  out_valid_o/out_ready_i factor_o
// cfg       in   apb psel/penable       max_radius @0, falloff_mode @4
//
// one item per cycle while the output is not stalled; stages in order: square, root load,
// 20 root stages, operand stage, divider load, 17 quotient stages, output register
// reset clears all valid bits and both registers to zero
// out stall freezes the whole pipe; in_ready_o follows the output slot
module light_distance_attenuation (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [lda_pkg::OffsetBits-1:0]  offset_x_i,
  input  logic signed [lda_pkg::OffsetBits-1:0]  offset_y_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [lda_pkg::FactorBits-1:0]         factor_o,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [lda_pkg::AddrBits-1:0]           paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);
  lda_pkg::cfg_t cfg;
  logic en;
  logic sq_vld, dv_vld;
  logic [lda_pkg::D2Bits-1:0]   d2;
  logic [lda_pkg::RootBits-1:0] root;
  logic [lda_pkg::FactorBits-1:0] fac;
  logic                           out_vld_q;
  logic [lda_pkg::FactorBits-1:0] out_fac_q;

  // pipe moves when the output slot is free or being taken
  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  lda_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg_o(cfg)
  );

  lda_sqrt_pipe u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i),
    .offset_x_i, .offset_y_i, .valid_o(sq_vld), .d2_o(d2), .root_o(root)
  );

  lda_div_pipe u_div (
    .clk_i, .rst_ni, .en_i(en), .cfg_i(cfg), .valid_i(sq_vld),
    .d2_i(d2), .root_i(root), .valid_o(dv_vld), .factor_o(fac)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) out_fac_q <= fac;
  end

  assign out_valid_o = out_vld_q;
  assign factor_o    = out_fac_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(factor_o))
    else $error("output item changed while stalled");
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> factor_o <= (lda_pkg::FactorBits'(1) << lda_pkg::FractionBits))
    else $error("factor above unity");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");
endmodule

### tb/tb_light_distance_attenuation.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_light_distance_attenuation
// streams tile offsets through the attenuation pipe under several radius and
// falloff settings and checks every factor against an in-bench fixed-point model
// ----------------------------------------------------------------------------
module tb_light_distance_attenuation;

  localparam int Latency = 42;

  typedef struct packed {
    logic signed [lda_pkg::OffsetBits-1:0] dx;
    logic signed [lda_pkg::OffsetBits-1:0] dy;
  } offset_t;

  logic                                  clk_i;
  logic                                  rst_ni;
  logic                                  in_valid_i;
  logic                                  in_ready_o;
  logic signed [lda_pkg::OffsetBits-1:0] offset_x_i;
  logic signed [lda_pkg::OffsetBits-1:0] offset_y_i;
  logic                                  out_valid_o;
  logic                                  out_ready_i;
  logic [lda_pkg::FactorBits-1:0]        factor_o;
  logic                                  psel;
  logic                                  penable;
  logic                                  pwrite;
  logic [lda_pkg::AddrBits-1:0]          paddr;
  logic [31:0]                           pwdata;
  logic [31:0]                           prdata;
  logic                                  pready;

  light_distance_attenuation uut (.*);

  // model copy of the registers
  logic [lda_pkg::RadiusBits-1:0] radius_q;
  lda_pkg::falloff_e              mode_q;

  offset_t                        pending_offsets[$];
  logic [lda_pkg::FactorBits-1:0] expected_factors[$];
  int                             errors = 0;
  int                             factors_seen = 0;
  int                             offsets_sent = 0;
  bit                             feed_enable;
  int                             gap_left;
  int                             burst_left;
  int                             hold_off;
  bit                             hold_req;
  bit                             hold_done;
  int                             stall_phase;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] root;
    logic [63:0] b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n = n - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic logic [lda_pkg::FactorBits-1:0] attenuation(input offset_t o);
    logic [63:0] ax, ay, d2, r, q, drop, r2, f, unity;
    unity = 64'd1 << lda_pkg::FractionBits;
    ax = (o.dx < 0) ? 64'(-int'(o.dx)) : 64'(o.dx);
    ay = (o.dy < 0) ? 64'(-int'(o.dy)) : 64'(o.dy);
    d2 = ax * ax + ay * ay;
    r = 64'(radius_q);
    if (r == 0) begin
      f = 0;
    end else if (mode_q == lda_pkg::ModeLinear) begin
      q = int_sqrt(d2 << 16);
      drop = (q << (lda_pkg::FractionBits - 8)) / r;
      f = (drop >= unity) ? 0 : unity - drop;
    end else begin
      r2 = r * r;
      f = (unity * r2) / (r2 + 4 * d2);
    end
    return f[lda_pkg::FactorBits-1:0];
  endfunction

  task automatic reg_write(input logic [lda_pkg::AddrBits-1:0] addr,
                           input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == lda_pkg::AddrRadius) radius_q = data[lda_pkg::RadiusBits-1:0];
    else if (addr == lda_pkg::AddrMode) mode_q = lda_pkg::falloff_e'(data[0]);
  endtask

  task automatic push_offset(input int x, input int y);
    offset_t o;
    o.dx = x[lda_pkg::OffsetBits-1:0];
    o.dy = y[lda_pkg::OffsetBits-1:0];
    pending_offsets.push_back(o);
  endtask

  task automatic push_random(input int n);
    int k;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 3) == 0)
        push_offset($urandom_range(0, 2047) - 1024, $urandom_range(0, 2047) - 1024);
      else
        push_offset(int'($urandom_range(0, 2 * radius_q + 8)) - int'(radius_q) - 4,
                    int'($urandom_range(0, 2 * radius_q + 8)) - int'(radius_q) - 4);
    end
  endtask

  // run one batch under the current registers and wait for the pipe to drain
  task automatic run_batch();
    feed_enable = 1'b1;
    wait (pending_offsets.size() == 0 && !in_valid_i && expected_factors.size() == 0);
    feed_enable = 1'b0;
    repeat (Latency + 5) @(posedge clk_i);
  endtask

  // driver: bursts with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      offset_x_i <= '0;
      offset_y_i <= '0;
      gap_left   <= 0;
      burst_left <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_factors.push_back(attenuation({offset_x_i, offset_y_i}));
        offsets_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (feed_enable && pending_offsets.size() > 0 && gap_left == 0) begin
          offset_t o;
          o = pending_offsets.pop_front();
          in_valid_i <= 1'b1;
          offset_x_i <= o.dx;
          offset_y_i <= o.dy;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 30);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end
      end
    end
  end

  // receiver stalls; one long hold-off fills the pipe
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_phase <= 0;
      hold_off    <= 0;
      hold_done   <= 1'b0;
    end else if (hold_req && !hold_done) begin
      out_ready_i <= 1'b0;
      hold_off    <= 150;
      hold_done   <= 1'b1;
    end else if (hold_off > 0) begin
      out_ready_i <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      stall_phase <= stall_phase + 1;
      if ((stall_phase / 200) % 2 == 0) out_ready_i <= 1'b1;
      else out_ready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      factors_seen++;
      if (expected_factors.size() == 0) begin
        $display("%0t: unexpected factor, expected none, actual %0d", $time, factor_o);
        errors++;
      end else begin
        logic [lda_pkg::FactorBits-1:0] want;
        want = expected_factors.pop_front();
        if (factor_o !== want) begin
          $display("%0t: factor mismatch, expected %0d, actual %0d", $time, want, factor_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("light_distance_attenuation verification failed");
    $finish;
  end

  initial begin
    feed_enable = 1'b0;
    hold_req = 1'b0;
    radius_q = '0;
    mode_q = lda_pkg::ModeLinear;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero radius after reset, with extremes
    push_offset(0, 0);
    push_offset(-1024, -1024);
    push_offset(1023, -1024);
    run_batch();

    // directed: upper bits of the writes must be dropped
    reg_write(lda_pkg::AddrRadius, 32'hFFFF_FC00 | 32'd10);
    reg_write(lda_pkg::AddrMode, 32'hFFFF_FFFE);
    push_offset(0, 0);
    push_offset(3, 4);
    push_offset(10, 0);
    push_offset(11, 0);
    push_offset(-1024, -1024);
    push_offset(1023, 1023);
    push_offset(-1024, 1023);
    push_offset(1, -1);
    run_batch();

    reg_write(lda_pkg::AddrMode, 32'(lda_pkg::ModeInvSq));
    push_offset(0, 0);
    push_offset(3, 4);
    push_offset(-1024, -1024);
    push_offset(1023, -1);
    push_offset(-5, 5);
    run_batch();

    reg_write(lda_pkg::AddrRadius, 32'd1023);
    push_offset(0, 0);
    push_offset(-1024, -1024);
    push_offset(1023, 0);
    push_offset(-723, 723);
    reg_write(lda_pkg::AddrMode, 32'(lda_pkg::ModeLinear));
    run_batch();
    push_offset(-1024, -1024);
    push_offset(1023, 0);
    push_offset(1, 0);
    run_batch();

    // random phases across settings
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: reg_write(lda_pkg::AddrRadius, 32'd1);
        1: reg_write(lda_pkg::AddrRadius, 32'd1023);
        2: reg_write(lda_pkg::AddrRadius, 32'd0);
        default: reg_write(lda_pkg::AddrRadius, $urandom_range(1, 1023));
      endcase
      reg_write(lda_pkg::AddrMode,
                32'((p % 2 == 0) ? lda_pkg::ModeLinear : lda_pkg::ModeInvSq));
      push_random(140);
      if (p == 4) begin
        fork
          run_batch();
          begin
            repeat (20) @(posedge clk_i);
            hold_req = 1'b1;
          end
        join
      end else begin
        run_batch();
      end
    end

    $display("sent %0d offsets, checked %0d factors over linear and inverse-square",
             offsets_sent, factors_seen);
    $display("radius settings from 0 to 1023, with stalls and one long output hold-off");
    if (errors == 0 && expected_factors.size() == 0) begin
      $display("light_distance_attenuation verification clean");
    end else begin
      $display("light_distance_attenuation verification failed");
    end
    $finish;
  end
endmodule

### sim.f
rtl/lda_pkg.sv
rtl/lda_regs.sv
rtl/lda_sqrt_pipe.sv
rtl/lda_div_pipe.sv
rtl/light_distance_attenuation.sv
tb/tb_light_distance_attenuation.sv
